>>> rtl/core/adsd_pkg.sv
// Shared types, constants and helpers for the angle detent step detector.
// No dependencies; used by every module of the core.
`default_nettype none
package adsd_pkg;

  localparam int ANGLE_W  = 12;  // units per turn = 2**ANGLE_W
  localparam int COUNT_W  = 7;
  localparam int SECTOR_W = 6;
  localparam int DIFF_W   = SECTOR_W + 2;
  localparam int PROD_W   = ANGLE_W + COUNT_W;

  localparam logic [COUNT_W-1:0] CNT_MIN = COUNT_W'(2);
  localparam logic [COUNT_W-1:0] CNT_MAX = COUNT_W'(64);

  localparam logic [COUNT_W-1:0] SECTOR_COUNT_RST = COUNT_W'(6);
  localparam logic               KEYS_ENABLED_RST = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_SECTOR_COUNT = 1'b0;
  localparam logic CFG_KEYS_ENABLED = 1'b1;

  // Request types.
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_REF    = 1'b1;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_LEFT  = 2'd1,
    EV_RIGHT = 2'd2
  } key_event_t;

  // Control handed from the datapath to the step tracker.
  typedef struct packed {
    logic                fire;     // an item moves into the result register
    logic                is_ref;
    logic                keys_en;
    logic [COUNT_W-1:0]  count;    // effective sector count
    logic [SECTOR_W-1:0] now;
  } step_req_t;

  function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] raw);
    logic [COUNT_W-1:0] c;
    c = raw;
    if (raw < CNT_MIN) c = CNT_MIN;
    else if (raw > CNT_MAX) c = CNT_MAX;
    return c;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/adsd_sector.sv
// Sector index from an angle: ((angle*n + half_turn) >> ANGLE_W) mod n.
// Depends on adsd_pkg.
`default_nettype none
module adsd_sector (
  input  wire logic [adsd_pkg::ANGLE_W-1:0]  angle,
  input  wire logic [adsd_pkg::COUNT_W-1:0]  count,
  output logic      [adsd_pkg::SECTOR_W-1:0] sector
);

  localparam logic [adsd_pkg::PROD_W-1:0] HALF_TURN =
    adsd_pkg::PROD_W'(1) << (adsd_pkg::ANGLE_W - 1);

  logic [adsd_pkg::PROD_W-1:0]  sum;
  logic [adsd_pkg::COUNT_W-1:0] raw;
  logic [adsd_pkg::COUNT_W-1:0] wrapped;

  always_comb begin
    sum = adsd_pkg::PROD_W'(angle) * adsd_pkg::PROD_W'(count) + HALF_TURN;
    raw = sum[adsd_pkg::ANGLE_W +: adsd_pkg::COUNT_W];
    // The sum never reaches 2*n turns, so one subtract brings it into range.
    wrapped = (raw >= count) ? (raw - count) : raw;
    sector = wrapped[adsd_pkg::SECTOR_W-1:0];
  end

endmodule
`default_nettype wire

>>> rtl/core/adsd_step.sv
// Stored sector register and left/right step decision.
// Depends on adsd_pkg.
`default_nettype none
module adsd_step (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire adsd_pkg::step_req_t  req,
  output adsd_pkg::key_event_t      key_event
);

  logic [adsd_pkg::SECTOR_W-1:0] stored_r, stored_nxt;
  logic signed [adsd_pkg::DIFF_W-1:0] diff, wrap, neg_wrap;
  logic is_left, is_right;

  always_comb begin
    diff     = $signed({2'b00, stored_r}) - $signed({2'b00, req.now});
    wrap     = $signed({1'b0, req.count}) - adsd_pkg::DIFF_W'(1);
    neg_wrap = -wrap;
    is_left  = (diff == -adsd_pkg::DIFF_W'(1)) || (diff == wrap);
    is_right = (diff == adsd_pkg::DIFF_W'(1)) || (diff == neg_wrap);

    key_event  = adsd_pkg::EV_NONE;
    stored_nxt = stored_r;
    if (req.is_ref) begin
      stored_nxt = req.now;
    end else if (req.keys_en) begin
      // Left is tested first; with two sectors both steps read as left.
      if (is_left) begin
        key_event  = adsd_pkg::EV_LEFT;
        stored_nxt = req.now;
      end else if (is_right) begin
        key_event  = adsd_pkg::EV_RIGHT;
        stored_nxt = req.now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stored_r <= '0;
    end else if (req.fire) begin
      stored_r <= stored_nxt;
    end
  end

  a_stored_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !req.fire |=> $stable(stored_r))
    else $error("stored sector changed without an item");

  a_ref_load: assert property (@(posedge clk) disable iff (!rst_n)
    req.fire && req.is_ref |=> stored_r == $past(req.now))
    else $error("reference item did not load the stored sector");

  a_event_moves: assert property (@(posedge clk) disable iff (!rst_n)
    req.fire && key_event != adsd_pkg::EV_NONE |=> stored_r == $past(req.now))
    else $error("key step did not update the stored sector");

endmodule
`default_nettype wire

>>> rtl/core/angle_detent_step_detector_core.sv
// Top level of the angle detent step detector: input register, sector
// datapath, step tracker and result register. Depends on adsd_pkg,
// adsd_sector and adsd_step.
//
//   Channel | Ports                                   | Direction
//   input   | in_valid, in_ready, in_req_type, in_angle | in (item in)
//   result  | out_valid, out_ready, out_key_event, out_sector | out (item out)
//   config  | cfg_we, cfg_index, cfg_wdata            | in (write only)
//
// An item is taken into the input register, and from there its result
// is written into the result register; one item per cycle is sustained while
// out_ready stays high. The stored sector is read and updated as the item enters
// the result register, so consecutive items see each other's updates.
// A stalled result register holds the input register, which then stalls in_.
// Reset clears both valid flags and the stored sector, and returns the config
// registers to their default values.
`default_nettype none
module angle_detent_step_detector_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           in_req_type,
  input  wire logic [adsd_pkg::ANGLE_W-1:0]   in_angle,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [1:0]                     out_key_event,
  output logic      [adsd_pkg::SECTOR_W-1:0]  out_sector,
  input  wire logic                           cfg_we,
  input  wire logic                           cfg_index,
  input  wire logic [adsd_pkg::COUNT_W-1:0]   cfg_wdata
);

  logic [adsd_pkg::COUNT_W-1:0]  sector_count_r;
  logic                          keys_enabled_r;
  logic                          s1_valid_r;
  logic                          s1_req_type_r;
  logic [adsd_pkg::ANGLE_W-1:0]  s1_angle_r;
  logic                          out_valid_r;
  logic [1:0]                    out_key_event_r;
  logic [adsd_pkg::SECTOR_W-1:0] out_sector_r;

  logic                          advance;
  logic [adsd_pkg::COUNT_W-1:0]  count;
  logic [adsd_pkg::SECTOR_W-1:0] now;
  adsd_pkg::step_req_t           step_req;
  adsd_pkg::key_event_t          key_event;

  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign count     = adsd_pkg::eff_count(sector_count_r);

  assign out_valid     = out_valid_r;
  assign out_key_event = out_key_event_r;
  assign out_sector    = out_sector_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sector_count_r <= adsd_pkg::SECTOR_COUNT_RST;
      keys_enabled_r <= adsd_pkg::KEYS_ENABLED_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        adsd_pkg::CFG_SECTOR_COUNT: sector_count_r <= cfg_wdata;
        adsd_pkg::CFG_KEYS_ENABLED: keys_enabled_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  adsd_sector u_sector (
    .angle  (s1_angle_r),
    .count  (count),
    .sector (now)
  );

  always_comb begin
    step_req.fire    = advance;
    step_req.is_ref  = (s1_req_type_r == adsd_pkg::REQ_REF);
    step_req.keys_en = keys_enabled_r;
    step_req.count   = count;
    step_req.now     = now;
  end

  adsd_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (step_req),
    .key_event (key_event)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_req_type_r <= in_req_type;
      s1_angle_r    <= in_angle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_key_event_r <= key_event;
      out_sector_r    <= now;
    end
  end

  a_no_bad_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_key_event_r != 2'd3)
    else $error("result carries an undefined key event code");

  a_ref_no_event: assert property (@(posedge clk) disable iff (!rst_n)
    advance && s1_req_type_r == adsd_pkg::REQ_REF |=> out_key_event_r == adsd_pkg::EV_NONE)
    else $error("reference item produced a key event");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !advance)
    else $error("result register overwritten while stalled");

  a_keys_off: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !keys_enabled_r |=> out_key_event_r == adsd_pkg::EV_NONE)
    else $error("key event produced while keys are disabled");

endmodule
`default_nettype wire
